>>> hdl/eqc_pkg.sv
// eqc_pkg: beat types, fixed-point widths, cordic arctangent table and
// rounding helpers shared by the euler/quaternion converter.
// no dependencies.
package eqc_pkg;

    // beat layouts
    typedef struct packed {
        logic               action;
        logic signed [31:0] in_roll;
        logic signed [31:0] in_pitch;
        logic signed [31:0] in_yaw;
        logic signed [31:0] in_w;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] out_w;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_roll;
        logic signed [31:0] out_pitch;
        logic signed [31:0] out_yaw;
        logic               pitch_clamped;
    } out_beat_t;

    localparam logic ACT_TO_QUAT  = 1'b0;
    localparam logic ACT_TO_EULER = 1'b1;

    localparam int CSTEPS     = 32;   // cordic iterations
    localparam int IFRAC      = 30;   // internal quaternion fraction bits
    localparam int QW         = 36;   // multiplier operand width
    localparam int MW         = 40;   // rounded product width
    localparam int OPW        = 40;   // arctangent operand width
    localparam int VEC_NORM   = 40;   // vectoring operands scaled up to 2^40
    localparam int NORM_STEPS = 6;    // 32,16,8,4,2,1 bit normalize shifts
    localparam int AT_LAT     = 2 + NORM_STEPS + CSTEPS;
    localparam int ISQ_STEPS  = 32;
    localparam int SQW        = 63;

    localparam logic [31:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [31:0] QUARTER_UP  = 32'h4000_0000;
    localparam logic [31:0] QUARTER_DN  = 32'hC000_0000;

    localparam logic signed [MW-1:0] ONE_Q = {{(MW-31){1'b0}}, 1'b1, 30'd0};
    localparam logic signed [MW-1:0] MINUS_ONE_Q = {{(MW-30){1'b1}}, 30'd0};
    localparam logic signed [MW-1:0] S32_MAX = {{(MW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [MW-1:0] S32_MIN = {{(MW-31){1'b1}}, 31'd0};
    localparam logic signed [2*QW-1:0] RND_HALF = (2*QW)'(64'd1 << (IFRAC - 1));

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_tab(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h2000_0000;
            1:  v = 32'h12E4_051E;
            2:  v = 32'h09FB_385B;
            3:  v = 32'h0511_11D4;
            4:  v = 32'h028B_0D43;
            5:  v = 32'h0145_D7E1;
            6:  v = 32'h00A2_F61E;
            7:  v = 32'h0051_7C55;
            8:  v = 32'h0028_BE53;
            9:  v = 32'h0014_5F2F;
            10: v = 32'h000A_2F98;
            11: v = 32'h0005_17CC;
            12: v = 32'h0002_8BE6;
            13: v = 32'h0001_45F3;
            14: v = 32'h0000_A2FA;
            15: v = 32'h0000_517D;
            16: v = 32'h0000_28BE;
            17: v = 32'h0000_145F;
            18: v = 32'h0000_0A30;
            19: v = 32'h0000_0518;
            20: v = 32'h0000_028C;
            21: v = 32'h0000_0146;
            22: v = 32'h0000_00A3;
            23: v = 32'h0000_0051;
            24: v = 32'h0000_0029;
            25: v = 32'h0000_0014;
            26: v = 32'h0000_000A;
            27: v = 32'h0000_0005;
            28: v = 32'h0000_0003;
            29: v = 32'h0000_0001;
            30: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // q30 product, rounded half up
    function automatic logic signed [MW-1:0] mulq(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        p = p + RND_HALF;
        p = p >>> IFRAC;
        return $signed(p[MW-1:0]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [MW-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

endpackage

>>> hdl/eqc_atan2.sv
// eqc_atan2: pipelined atan2 by vectoring cordic, result in binary angle.
// every stage advances when en is high. uses eqc_pkg.
module eqc_atan2
    import eqc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [OPW-1:0] y_in,
    input  logic signed [OPW-1:0] x_in,
    output logic [31:0]           angle
);

    localparam int AW = VEC_NORM + 1;
    localparam int NW = AW + 2;
    localparam int CW = NW + 2;

    // half-plane fold
    logic signed [AW-1:0] ax_reg, ay_reg;
    logic [31:0]          az_reg;
    logic                 azr_reg;

    // normalize chain, entry 0 holds the magnitude stage
    logic signed [NW-1:0] nx_reg [NORM_STEPS+1];
    logic signed [NW-1:0] ny_reg [NORM_STEPS+1];
    logic [AW-1:0]        nm_reg [NORM_STEPS+1];
    logic [31:0]          nz_reg [NORM_STEPS+1];
    logic                 nzr_reg [NORM_STEPS+1];

    logic signed [CW-1:0] cx_reg [CSTEPS];
    logic signed [CW-1:0] cy_reg [CSTEPS];
    logic [31:0]          cz_reg [CSTEPS];
    logic                 czr_reg [CSTEPS];

    logic signed [CW-1:0] cx_in [CSTEPS];
    logic signed [CW-1:0] cy_in [CSTEPS];
    logic [31:0]          cz_in [CSTEPS];
    logic                 czr_in [CSTEPS];

    logic signed [AW-1:0] xe, ye;
    logic [AW-1:0]        abs_x, abs_y;

    assign xe = {x_in[OPW-1], x_in};
    assign ye = {y_in[OPW-1], y_in};

    always_ff @(posedge aclk) begin
        if (en) begin
            azr_reg <= (x_in == '0) && (y_in == '0);
            if (x_in[OPW-1]) begin
                ax_reg <= -xe;
                ay_reg <= -ye;
                az_reg <= HALF_TURN;
            end else begin
                ax_reg <= xe;
                ay_reg <= ye;
                az_reg <= '0;
            end
        end
    end

    assign abs_x = ax_reg[AW-1] ? AW'(-ax_reg) : AW'(ax_reg);
    assign abs_y = ay_reg[AW-1] ? AW'(-ay_reg) : AW'(ay_reg);

    // largest doubling that keeps max(|x|,|y|) below 2^(VEC_NORM+1)
    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg[0]  <= {{(NW-AW){ax_reg[AW-1]}}, ax_reg};
            ny_reg[0]  <= {{(NW-AW){ay_reg[AW-1]}}, ay_reg};
            nm_reg[0]  <= abs_x | abs_y;
            nz_reg[0]  <= az_reg;
            nzr_reg[0] <= azr_reg;
            for (int j = 0; j < NORM_STEPS; j++) begin
                nz_reg[j+1]  <= nz_reg[j];
                nzr_reg[j+1] <= nzr_reg[j];
                if ((nm_reg[j] >> (AW - (1 << (NORM_STEPS - 1 - j)))) == '0) begin
                    nx_reg[j+1] <= nx_reg[j] <<< (1 << (NORM_STEPS - 1 - j));
                    ny_reg[j+1] <= ny_reg[j] <<< (1 << (NORM_STEPS - 1 - j));
                    nm_reg[j+1] <= nm_reg[j] << (1 << (NORM_STEPS - 1 - j));
                end else begin
                    nx_reg[j+1] <= nx_reg[j];
                    ny_reg[j+1] <= ny_reg[j];
                    nm_reg[j+1] <= nm_reg[j];
                end
            end
        end
    end

    always_comb begin
        cx_in[0]  = {{(CW-NW){nx_reg[NORM_STEPS][NW-1]}}, nx_reg[NORM_STEPS]};
        cy_in[0]  = {{(CW-NW){ny_reg[NORM_STEPS][NW-1]}}, ny_reg[NORM_STEPS]};
        cz_in[0]  = nz_reg[NORM_STEPS];
        czr_in[0] = nzr_reg[NORM_STEPS];
        for (int i = 1; i < CSTEPS; i++) begin
            cx_in[i]  = cx_reg[i-1];
            cy_in[i]  = cy_reg[i-1];
            cz_in[i]  = cz_reg[i-1];
            czr_in[i] = czr_reg[i-1];
        end
    end

    // drive y toward zero, accumulating the angle
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < CSTEPS; i++) begin
                czr_reg[i] <= czr_in[i];
                if (!cy_in[i][CW-1]) begin
                    cx_reg[i] <= cx_in[i] + (cy_in[i] >>> i);
                    cy_reg[i] <= cy_in[i] - (cx_in[i] >>> i);
                    cz_reg[i] <= cz_in[i] + atan_tab(i);
                end else begin
                    cx_reg[i] <= cx_in[i] - (cy_in[i] >>> i);
                    cy_reg[i] <= cy_in[i] + (cx_in[i] >>> i);
                    cz_reg[i] <= cz_in[i] - atan_tab(i);
                end
            end
        end
    end

    assign angle = czr_reg[CSTEPS-1] ? '0 : cz_reg[CSTEPS-1];

endmodule

>>> hdl/euler_quaternion_convert.sv
// euler_quaternion_convert: zyx euler angles <-> unit quaternion, fixed point,
// rotation cordic for sin/cos, pipelined isqrt and eqc_atan2 for the angles.
// uses eqc_pkg and eqc_atan2.
//
//   channel   ports                       payload      direction
//   s_        s_valid, s_ready, s_data    in_beat_t    in
//   m_        m_valid, m_ready, m_data    out_beat_t   out
//
// one beat enters per cycle while the pipeline is not held; the delay from s_ to m_
// is set by the 32-step isqrt followed by the 40-stage atan2 pipeline.
// reset clears only the stage valid bits; no warm-up pass is needed.
// the whole pipeline holds while m_valid is high and m_ready is low,
// so s_ready follows that condition.
module euler_quaternion_convert
    import eqc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int LAT    = 4 + ISQ_STEPS + AT_LAT + 1;
    localparam int Q_DLY  = LAT - 1 - (CSTEPS + 4);
    localparam int RY_DLY = ISQ_STEPS + 1;
    localparam int CL_DLY = AT_LAT;
    localparam int LANES  = 3;
    localparam int RW     = 44;
    localparam int RZ     = 33;
    localparam int CRW    = 34;

    localparam logic signed [RW-1:0] KGAIN_Q40 = RW'(64'd652032874 << 10);
    localparam logic signed [RW-1:0] RND_ROT   = RW'(512);
    localparam logic [SQW-1:0]       SQ_ONE    = SQW'(64'd1 << 60);

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } quat_t;

    typedef struct packed {
        logic [31:0] roll;
        logic [31:0] yaw;
    } ang_pair_t;

    typedef struct packed {
        logic cpos;
        logic cneg;
    } clamp_t;

    typedef struct packed {
        logic [SQW-1:0]     op;
        logic [SQW-1:0]     root;
        logic signed [30:0] sv;
        clamp_t             clamp;
    } isq_stage_t;

    function automatic logic signed [QW-1:0] from_rot(input logic signed [CRW-1:0] v);
        return {{(QW-CRW){v[CRW-1]}}, v};
    endfunction

    function automatic logic signed [QW-1:0] from_quat(input logic signed [31:0] v);
        return {{(QW-32){v[31]}}, v};
    endfunction

    function automatic logic signed [QW-1:0] from_prod(input logic signed [MW-1:0] v);
        return $signed(v[QW-1:0]);
    endfunction

    function automatic logic signed [RZ-1:0] tab_z(input int idx);
        return $signed({1'b0, atan_tab(idx)});
    endfunction

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-3:0] act_reg;
    in_beat_t       in_reg;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg  <= s_data;
            act_reg <= {act_reg[LAT-4:0], in_reg.action};
        end
    end

    // ---------------- euler -> quaternion ----------------

    logic signed [RZ-1:0] half [LANES];
    logic signed [RW-1:0] rx_in [LANES][CSTEPS];
    logic signed [RW-1:0] ry_in [LANES][CSTEPS];
    logic signed [RZ-1:0] rz_in [LANES][CSTEPS];
    logic signed [RW-1:0] rx_reg [LANES][CSTEPS];
    logic signed [RW-1:0] ry_reg [LANES][CSTEPS];
    logic signed [RZ-1:0] rz_reg [LANES][CSTEPS];
    logic signed [RW-1:0] rnd_c [LANES];
    logic signed [RW-1:0] rnd_s [LANES];
    logic signed [CRW-1:0] rc_reg [LANES];
    logic signed [CRW-1:0] rs_reg [LANES];

    always_comb begin
        half[0] = {{2{in_reg.in_roll[31]}}, in_reg.in_roll[31:1]};
        half[1] = {{2{in_reg.in_pitch[31]}}, in_reg.in_pitch[31:1]};
        half[2] = {{2{in_reg.in_yaw[31]}}, in_reg.in_yaw[31:1]};
        for (int l = 0; l < LANES; l++) begin
            rx_in[l][0] = KGAIN_Q40;
            ry_in[l][0] = '0;
            rz_in[l][0] = half[l];
            for (int i = 1; i < CSTEPS; i++) begin
                rx_in[l][i] = rx_reg[l][i-1];
                ry_in[l][i] = ry_reg[l][i-1];
                rz_in[l][i] = rz_reg[l][i-1];
            end
            rnd_c[l] = rx_reg[l][CSTEPS-1] + RND_ROT;
            rnd_s[l] = ry_reg[l][CSTEPS-1] + RND_ROT;
        end
    end

    // rotate by the residual angle, positive when z is non-negative
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                for (int i = 0; i < CSTEPS; i++) begin
                    if (!rz_in[l][i][RZ-1]) begin
                        rx_reg[l][i] <= rx_in[l][i] - (ry_in[l][i] >>> i);
                        ry_reg[l][i] <= ry_in[l][i] + (rx_in[l][i] >>> i);
                        rz_reg[l][i] <= rz_in[l][i] - tab_z(i);
                    end else begin
                        rx_reg[l][i] <= rx_in[l][i] + (ry_in[l][i] >>> i);
                        ry_reg[l][i] <= ry_in[l][i] - (rx_in[l][i] >>> i);
                        rz_reg[l][i] <= rz_in[l][i] + tab_z(i);
                    end
                end
                rc_reg[l] <= $signed(rnd_c[l][RW-1:10]);
                rs_reg[l] <= $signed(rnd_s[l][RW-1:10]);
            end
        end
    end

    // lanes: 0 roll, 1 pitch, 2 yaw
    logic signed [MW-1:0]  pcc_reg, psc_reg, pcs_reg, pss_reg;
    logic signed [CRW-1:0] cy_reg, sy_reg;
    logic signed [MW-1:0]  t_ccy_reg, t_sss_reg, t_scy_reg, t_css_reg;
    logic signed [MW-1:0]  t_csy_reg, t_scs_reg, t_ccs_reg, t_ssy_reg;
    quat_t                 qdl_reg [Q_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            pcc_reg <= mulq(from_rot(rc_reg[0]), from_rot(rc_reg[1]));
            psc_reg <= mulq(from_rot(rs_reg[0]), from_rot(rc_reg[1]));
            pcs_reg <= mulq(from_rot(rc_reg[0]), from_rot(rs_reg[1]));
            pss_reg <= mulq(from_rot(rs_reg[0]), from_rot(rs_reg[1]));
            cy_reg  <= rc_reg[2];
            sy_reg  <= rs_reg[2];

            t_ccy_reg <= mulq(from_prod(pcc_reg), from_rot(cy_reg));
            t_sss_reg <= mulq(from_prod(pss_reg), from_rot(sy_reg));
            t_scy_reg <= mulq(from_prod(psc_reg), from_rot(cy_reg));
            t_css_reg <= mulq(from_prod(pcs_reg), from_rot(sy_reg));
            t_csy_reg <= mulq(from_prod(pcs_reg), from_rot(cy_reg));
            t_scs_reg <= mulq(from_prod(psc_reg), from_rot(sy_reg));
            t_ccs_reg <= mulq(from_prod(pcc_reg), from_rot(sy_reg));
            t_ssy_reg <= mulq(from_prod(pss_reg), from_rot(cy_reg));

            qdl_reg[0].w <= sat32(t_ccy_reg + t_sss_reg);
            qdl_reg[0].x <= sat32(t_scy_reg - t_css_reg);
            qdl_reg[0].y <= sat32(t_csy_reg + t_scs_reg);
            qdl_reg[0].z <= sat32(t_ccs_reg - t_ssy_reg);
            for (int k = 1; k < Q_DLY; k++) begin
                qdl_reg[k] <= qdl_reg[k-1];
            end
        end
    end

    // ---------------- quaternion -> euler ----------------

    logic signed [MW-1:0] p_wy_reg, p_xz_reg, p_wx_reg, p_yz_reg, p_xx_reg;
    logic signed [MW-1:0] p_yy_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    logic signed [MW-1:0] sinp_reg, rnum_reg, rden_reg, ynum_reg, yden_reg;
    logic signed [30:0]   sv;
    logic signed [61:0]   sv_sq;
    isq_stage_t           sq_reg;
    isq_stage_t           isq_in [ISQ_STEPS];
    isq_stage_t           isq_next [ISQ_STEPS];
    isq_stage_t           isq_reg [ISQ_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_wy_reg <= mulq(from_quat(in_reg.in_w), from_quat(in_reg.in_y));
            p_xz_reg <= mulq(from_quat(in_reg.in_x), from_quat(in_reg.in_z));
            p_wx_reg <= mulq(from_quat(in_reg.in_w), from_quat(in_reg.in_x));
            p_yz_reg <= mulq(from_quat(in_reg.in_y), from_quat(in_reg.in_z));
            p_xx_reg <= mulq(from_quat(in_reg.in_x), from_quat(in_reg.in_x));
            p_yy_reg <= mulq(from_quat(in_reg.in_y), from_quat(in_reg.in_y));
            p_wz_reg <= mulq(from_quat(in_reg.in_w), from_quat(in_reg.in_z));
            p_xy_reg <= mulq(from_quat(in_reg.in_x), from_quat(in_reg.in_y));
            p_zz_reg <= mulq(from_quat(in_reg.in_z), from_quat(in_reg.in_z));

            sinp_reg <= (p_wy_reg - p_xz_reg) <<< 1;
            rnum_reg <= (p_wx_reg + p_yz_reg) <<< 1;
            rden_reg <= ONE_Q - ((p_xx_reg + p_yy_reg) <<< 1);
            ynum_reg <= (p_wz_reg + p_xy_reg) <<< 1;
            yden_reg <= ONE_Q - ((p_yy_reg + p_zz_reg) <<< 1);
        end
    end

    // cosine of pitch = sqrt(1 - s^2), only meaningful when not clamped
    assign sv    = $signed(sinp_reg[30:0]);
    assign sv_sq = sv * sv;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg.op         <= SQ_ONE - {1'b0, sv_sq};
            sq_reg.root       <= '0;
            sq_reg.sv         <= sv;
            sq_reg.clamp.cpos <= sinp_reg >= ONE_Q;
            sq_reg.clamp.cneg <= sinp_reg <= MINUS_ONE_Q;
        end
    end

    always_comb begin
        isq_in[0] = sq_reg;
        for (int k = 1; k < ISQ_STEPS; k++) begin
            isq_in[k] = isq_reg[k-1];
        end
    end

    // one result bit per stage
    always_comb begin
        logic [SQW-1:0] bit_one;
        logic [SQW-1:0] trial;
        for (int k = 0; k < ISQ_STEPS; k++) begin
            bit_one     = SQW'(1) << (SQW - 1 - 2 * k);
            trial       = isq_in[k].root + bit_one;
            isq_next[k] = isq_in[k];
            if (isq_in[k].op >= trial) begin
                isq_next[k].op   = isq_in[k].op - trial;
                isq_next[k].root = (isq_in[k].root >> 1) + bit_one;
            end else begin
                isq_next[k].root = isq_in[k].root >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ISQ_STEPS; k++) begin
                isq_reg[k] <= isq_next[k];
            end
        end
    end

    logic signed [OPW-1:0] pitch_y, pitch_x;
    logic [31:0]           pitch_ang, roll_ang, yaw_ang;
    ang_pair_t             rdl_reg [RY_DLY];
    clamp_t                cdl_reg [CL_DLY];

    assign pitch_y = {{(OPW-31){isq_reg[ISQ_STEPS-1].sv[30]}}, isq_reg[ISQ_STEPS-1].sv};
    assign pitch_x = $signed(isq_reg[ISQ_STEPS-1].root[OPW-1:0]);

    eqc_atan2 u_pitch (
        .aclk  (aclk),
        .en    (en),
        .y_in  (pitch_y),
        .x_in  (pitch_x),
        .angle (pitch_ang)
    );

    eqc_atan2 u_roll (
        .aclk  (aclk),
        .en    (en),
        .y_in  (rnum_reg),
        .x_in  (rden_reg),
        .angle (roll_ang)
    );

    eqc_atan2 u_yaw (
        .aclk  (aclk),
        .en    (en),
        .y_in  (ynum_reg),
        .x_in  (yden_reg),
        .angle (yaw_ang)
    );

    // roll and yaw finish early, hold them until pitch catches up
    always_ff @(posedge aclk) begin
        if (en) begin
            rdl_reg[0].roll <= roll_ang;
            rdl_reg[0].yaw  <= yaw_ang;
            for (int k = 1; k < RY_DLY; k++) begin
                rdl_reg[k] <= rdl_reg[k-1];
            end
            cdl_reg[0] <= isq_reg[ISQ_STEPS-1].clamp;
            for (int k = 1; k < CL_DLY; k++) begin
                cdl_reg[k] <= cdl_reg[k-1];
            end
        end
    end

    // ---------------- output beat ----------------

    out_beat_t out_next;
    out_beat_t out_reg;

    always_comb begin
        out_next = '0;
        if (act_reg[LAT-3] == ACT_TO_EULER) begin
            out_next.out_roll = $signed(rdl_reg[RY_DLY-1].roll);
            out_next.out_yaw  = $signed(rdl_reg[RY_DLY-1].yaw);
            if (cdl_reg[CL_DLY-1].cpos) begin
                out_next.out_pitch = $signed(QUARTER_UP);
            end else if (cdl_reg[CL_DLY-1].cneg) begin
                out_next.out_pitch = $signed(QUARTER_DN);
            end else begin
                out_next.out_pitch = $signed(pitch_ang);
            end
            out_next.pitch_clamped = cdl_reg[CL_DLY-1].cpos || cdl_reg[CL_DLY-1].cneg;
        end else begin
            out_next.out_w = qdl_reg[Q_DLY-1].w;
            out_next.out_x = qdl_reg[Q_DLY-1].x;
            out_next.out_y = qdl_reg[Q_DLY-1].y;
            out_next.out_z = qdl_reg[Q_DLY-1].z;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

>>> test/tb_euler_quaternion_convert.sv
// tb_euler_quaternion_convert: self-checking bench for the zyx euler/quaternion
// converter, with its own bit-exact cordic predictor and random handshakes.
// depends on eqc_pkg and euler_quaternion_convert.
module tb_euler_quaternion_convert;
    import eqc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam longint Q_ONE = 64'sd1 <<< 30;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    out_beat_t attitude_q[$];
    int        mismatch_cnt = 0;
    int        beats_checked = 0;
    int        clamp_seen = 0;
    int        cycle_cnt = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;

    longint atan_lut [0:31] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 64'h00000000};

    euler_quaternion_convert uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [31:0] clip_s32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void half_sincos(longint z, output longint c, output longint s);
        longint x, y, dx, dy;
        x = 64'sd652032874 * 1024;
        y = 0;
        for (int i = 0; i < 32; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x = x - dy; y = y + dx; z = z - atan_lut[i];
            end else begin
                x = x + dy; y = y - dx; z = z + atan_lut[i];
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
    endfunction

    function automatic logic [31:0] angle_of(longint y, longint x);
        logic [31:0] z;
        longint dx, dy;
        z = 32'd0;
        if (x == 0 && y == 0) begin
            return 32'd0;
        end
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
            x = x * 2; y = y * 2;
        end
        for (int i = 0; i < 32; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
                x = x + dy; y = y - dx; z = z + atan_lut[i][31:0];
            end else begin
                x = x - dy; y = y + dx; z = z - atan_lut[i][31:0];
            end
        end
        return z;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] op);
        logic [63:0] res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > op) one = one >> 2;
        while (one != 0) begin
            if (op >= res + one) begin
                op = op - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic out_beat_t convert_attitude(in_beat_t b);
        out_beat_t r;
        longint cr, sr, cp, sp, cy, sy, w, x, y, z, sinp;
        logic [63:0] cosp;
        logic [31:0] pitch;
        r = '0;
        if (b.action == ACT_TO_QUAT) begin
            half_sincos(longint'(b.in_roll) >>> 1, cr, sr);
            half_sincos(longint'(b.in_pitch) >>> 1, cp, sp);
            half_sincos(longint'(b.in_yaw) >>> 1, cy, sy);
            r.out_w = clip_s32(q30_mul(q30_mul(cr, cp), cy) + q30_mul(q30_mul(sr, sp), sy));
            r.out_x = clip_s32(q30_mul(q30_mul(sr, cp), cy) - q30_mul(q30_mul(cr, sp), sy));
            r.out_y = clip_s32(q30_mul(q30_mul(cr, sp), cy) + q30_mul(q30_mul(sr, cp), sy));
            r.out_z = clip_s32(q30_mul(q30_mul(cr, cp), sy) - q30_mul(q30_mul(sr, sp), cy));
        end else begin
            w = longint'(b.in_w);
            x = longint'(b.in_x);
            y = longint'(b.in_y);
            z = longint'(b.in_z);
            sinp = 2 * (q30_mul(w, y) - q30_mul(x, z));
            if (sinp >= Q_ONE) begin
                pitch = QUARTER_UP;
                r.pitch_clamped = 1'b1;
            end else if (sinp <= -Q_ONE) begin
                pitch = QUARTER_DN;
                r.pitch_clamped = 1'b1;
            end else begin
                cosp = int_sqrt((64'd1 << 60) - 64'(sinp * sinp));
                pitch = angle_of(sinp, longint'(cosp));
            end
            r.out_roll = angle_of(2 * (q30_mul(w, x) + q30_mul(y, z)),
                                  Q_ONE - 2 * (q30_mul(x, x) + q30_mul(y, y)));
            r.out_pitch = pitch;
            r.out_yaw = angle_of(2 * (q30_mul(w, z) + q30_mul(x, y)),
                                 Q_ONE - 2 * (q30_mul(y, y) + q30_mul(z, z)));
        end
        return r;
    endfunction

    // receiver stalls picked once per cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("euler_quaternion_convert regression: fail");
            $finish;
        end
    end

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            mismatch_cnt++;
            $display("%0t mismatch %s: expected %h actual %h", $realtime, name, e, a);
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (attitude_q.size() == 0) begin
                mismatch_cnt++;
                $display("%0t unexpected beat: expected none actual %h", $realtime, m_data);
            end else begin
                e = attitude_q.pop_front();
                check_field("out_w", e.out_w, m_data.out_w);
                check_field("out_x", e.out_x, m_data.out_x);
                check_field("out_y", e.out_y, m_data.out_y);
                check_field("out_z", e.out_z, m_data.out_z);
                check_field("out_roll", e.out_roll, m_data.out_roll);
                check_field("out_pitch", e.out_pitch, m_data.out_pitch);
                check_field("out_yaw", e.out_yaw, m_data.out_yaw);
                check_field("pitch_clamped", 32'(e.pitch_clamped), 32'(m_data.pitch_clamped));
                beats_checked++;
                if (e.pitch_clamped) clamp_seen++;
            end
        end
    end

    // called right after reset or an accepting edge
    task automatic send_beat(in_beat_t b);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        attitude_q.push_back(convert_attitude(b));
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic in_beat_t noise_beat(logic act);
        in_beat_t b;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(in_beat_t)-1:0];
        b.action = act;
        return b;
    endfunction

    function automatic in_beat_t euler_beat(logic [31:0] r, logic [31:0] p, logic [31:0] y);
        in_beat_t b;
        b = noise_beat(ACT_TO_QUAT);
        b.in_roll = r; b.in_pitch = p; b.in_yaw = y;
        return b;
    endfunction

    function automatic in_beat_t quat_beat(logic [31:0] w, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z);
        in_beat_t b;
        b = noise_beat(ACT_TO_EULER);
        b.in_w = w; b.in_x = x; b.in_y = y; b.in_z = z;
        return b;
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return QUARTER_UP + $urandom_range(4) - 2;
            3: return QUARTER_DN + $urandom_range(4) - 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_euler_to_quat_directed();
        send_beat(euler_beat(0, 0, 0));
        send_beat(euler_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_beat(euler_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_beat(euler_beat(QUARTER_UP, QUARTER_UP, QUARTER_UP));
        send_beat(euler_beat(QUARTER_DN, QUARTER_DN, QUARTER_DN));
        send_beat(euler_beat(32'h2000_0000, QUARTER_UP, 32'hE000_0000));
        send_beat(euler_beat(32'hFFFF_FFFF, 1, 32'h8000_0001));
        send_beat(euler_beat(32'h1234_5678, 32'hEDCB_A988, 32'h5555_5555));
    endtask

    task automatic test_quat_to_euler_directed();
        send_beat(quat_beat(32'h4000_0000, 0, 0, 0));
        send_beat(quat_beat(0, 0, 0, 0));
        send_beat(quat_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_beat(quat_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_beat(quat_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        // pitch sine exactly plus and minus one
        send_beat(quat_beat(32'h2D41_3CCD, 0, 32'h2D41_3CCD, 0));
        send_beat(quat_beat(32'h2D41_3CCD, 0, 32'hD2BE_C333, 0));
        send_beat(quat_beat(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'hE000_0000));
        // roll arctangent with both operands zero
        send_beat(quat_beat(0, 32'h2000_0000, 32'h2000_0000, 0));
        // non-unit input
        send_beat(quat_beat(32'h1000_0000, 32'h0100_0000, 32'hF000_0000, 32'h0000_0001));
        send_beat(quat_beat(32'hC000_0000, 0, 0, 0));
    endtask

    task automatic test_random_mix(int tx_pct, int rx_pct, int n);
        in_beat_t b;
        out_beat_t q;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2: b = euler_beat(pick_angle(), pick_angle(), pick_angle());
                3: b = noise_beat(ACT_TO_EULER);
                default: begin
                    // well-formed quaternion from random angles
                    q = convert_attitude(euler_beat(pick_angle(), pick_angle(), pick_angle()));
                    b = quat_beat(q.out_w, q.out_x, q.out_y, q.out_z);
                end
            endcase
            send_beat(b);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        rx_idle_pct = 30;
        test_euler_to_quat_directed();
        test_quat_to_euler_directed();
        test_random_mix(17, 87, 360);
        test_random_mix(87, 17, 360);
        test_random_mix(0, 0, 380);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (attitude_q.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        $display("checked %0d beats (%0d with pitch clamped), both directions, three stall mixes",
                 beats_checked, clamp_seen);
        if (mismatch_cnt == 0 && attitude_q.size() == 0) begin
            $display("euler_quaternion_convert regression: pass");
        end else begin
            $display("euler_quaternion_convert regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/eqc_pkg.sv
hdl/eqc_atan2.sv
hdl/euler_quaternion_convert.sv
test/tb_euler_quaternion_convert.sv
